### rtl/integer_to_ascii_converter_core_macros.svh
// assertion macros shared by the integer to ascii converter rtl
// no dependencies; included by the files that carry assertions
`ifndef INTEGER_TO_ASCII_CONVERTER_CORE_MACROS_SVH
`define INTEGER_TO_ASCII_CONVERTER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ITOA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("itoa same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define ITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("itoa next-cycle check failed");

`endif

### rtl/itoa_pkg.sv
// shared types, constants and functions of the integer to ascii converter
// no dependencies
package itoa_pkg;

	localparam int ACTION_W = 2;
	localparam int VALUE_W  = 32;
	localparam int CHAR_W   = 8;
	localparam int CNT_W    = 4;

	// format codes of the action field
	localparam logic [ACTION_W-1:0] FMT_UNSIGNED = 2'd0;
	localparam logic [ACTION_W-1:0] FMT_SIGNED   = 2'd1;
	localparam logic [ACTION_W-1:0] FMT_HEX      = 2'd2;
	// bit of the action field that selects hex (hex and the unused code)
	localparam int FMT_HEX_BIT = 1;

	localparam logic [CNT_W-1:0] MAX_DEC_DIGITS = 4'd10;
	localparam int HEX_DIGITS = 8;

	// reciprocal of ten for a 32-bit dividend: q = (x * RECIP) >> RECIP_SHIFT
	localparam logic [VALUE_W-1:0] RECIP_DIV10 = 32'hCCCC_CCCD;
	localparam int RECIP_SHIFT = 35;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	localparam logic [CHAR_W-1:0] GLYPHS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	// classified number handed from front to back
	typedef struct packed {
		logic               hex;
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} itoa_cmd_t;

	function automatic logic [CHAR_W-1:0] glyph(input logic [3:0] digit);
		return GLYPHS[digit];
	endfunction

endpackage

### rtl/itoa_if.sv
// valid/ready channel interfaces for numbers in and characters out
// depends on itoa_pkg
interface itoa_num_if
	import itoa_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [VALUE_W-1:0]  value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

interface itoa_chr_if
	import itoa_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              last;

	modport source (output valid, output char_code, output last, input ready);
	modport sink   (input valid, input char_code, input last, output ready);
endinterface

### rtl/integer_to_ascii_converter_core.sv
// integer to ascii converter: one number in, its characters out one per item
// the front and the queue take further numbers while the back end works; the back end takes
// the next number once the last character of the current one is in its output register
// a decimal number has at most 11 characters; the digit loop and the single output register set the rate
// reset: arst_n clears the queue, the sequencer and all valid flags at once
// depends on itoa_pkg, itoa_if, itoa_front, itoa_queue and itoa_back
module integer_to_ascii_converter_core
	import itoa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	itoa_num_if.sink   num,
	itoa_chr_if.source chr
);

	logic      f_valid;
	logic      f_ready;
	itoa_cmd_t f_cmd;
	logic      b_valid;
	logic      b_ready;
	itoa_cmd_t b_cmd;

	// accept and classify
	itoa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.num       (num),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	// decoupling queue
	itoa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_cmd   (f_cmd),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_cmd    (b_cmd)
	);

	// digit generation and character output
	itoa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd       (b_cmd),
		.chr       (chr)
	);

endmodule

### rtl/itoa_front.sv
// front end: accepts numbers, picks the format and forms the magnitude
// depends on itoa_pkg and itoa_num_if
module itoa_front
	import itoa_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	itoa_num_if.sink        num,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output itoa_cmd_t       cmd
);

	logic      v_s1;
	itoa_cmd_t cmd_s1;
	itoa_cmd_t cls;
	logic      take;

	// classify the incoming item
	always_comb begin
		cls.hex = num.action[FMT_HEX_BIT];
		cls.neg = (num.action == FMT_SIGNED) && num.value[VALUE_W-1];
		cls.mag = cls.neg ? (~num.value + 1'b1) : num.value;
	end

	assign num.ready = !v_s1 || cmd_ready;
	assign take      = num.valid && num.ready;

	// one stage register toward the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (cmd_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cls;
		end
	end

	assign cmd_valid = v_s1;
	assign cmd       = cmd_s1;

endmodule

### rtl/itoa_queue.sv
// small command queue that decouples front and back
// depends on itoa_pkg
module itoa_queue
	import itoa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  itoa_cmd_t push_cmd,
	output logic      pop_valid,
	input  logic      pop_ready,
	output itoa_cmd_t pop_cmd
);

	itoa_cmd_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               push;
	logic               pop;

	assign push_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### rtl/itoa_back.sv
// back end: splits the magnitude into digits and sends characters out
// depends on itoa_pkg, itoa_chr_if and the assertion macros
`include "integer_to_ascii_converter_core_macros.svh"

module itoa_back
	import itoa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  itoa_cmd_t cmd,
	itoa_chr_if.source chr
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [VALUE_W-1:0] mag_q;
	logic               neg_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   pos_q;
	logic [3:0]         dig_q [MAX_DEC_DIGITS];
	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	logic [2*VALUE_W-1:0] prod;
	logic [VALUE_W-1:0]   quo;
	logic [VALUE_W-1:0]   quo10;
	logic [VALUE_W-1:0]   diff;
	logic [3:0]           rem;
	logic [CNT_W-1:0]     hex_len;
	logic                 out_free;
	logic                 emit;
	logic [CHAR_W-1:0]    next_char;

	// number of hex digits without leading zeros, at least one
	function automatic logic [CNT_W-1:0] hex_count(input logic [VALUE_W-1:0] v);
		logic [CNT_W-1:0] n;
		n = CNT_W'(1);
		for (int i = 0; i < HEX_DIGITS; i++) begin
			if (v[4*i +: 4] != 4'd0) begin
				n = CNT_W'(i + 1);
			end
		end
		return n;
	endfunction

	// divide by ten through the reciprocal, remainder by shift and add
	always_comb begin
		prod  = {{VALUE_W{1'b0}}, mag_q} * {{VALUE_W{1'b0}}, RECIP_DIV10};
		quo   = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
		quo10 = (quo << 3) + (quo << 1);
		diff  = mag_q - quo10;
		rem   = diff[3:0];
	end

	assign hex_len  = hex_count(cmd.mag);
	assign out_free = !out_valid_q || chr.ready;
	assign emit     = (state_q == ST_EMIT) && out_free;
	assign next_char = (neg_q && pos_q == cnt_q) ? CHAR_MINUS : glyph(dig_q[pos_q]);
	assign cmd_ready = (state_q == ST_IDLE);

	// sequencer with digit store and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// output valid: set on a new character, cleared once taken
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (chr.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						if (cmd.hex) begin
							for (int i = 0; i < HEX_DIGITS; i++) begin
								dig_q[i] <= cmd.mag[4*i +: 4];
							end
							cnt_q   <= hex_len;
							pos_q   <= hex_len - 1'b1;
							neg_q   <= 1'b0;
							state_q <= ST_EMIT;
						end else begin
							mag_q   <= cmd.mag;
							neg_q   <= cmd.neg;
							cnt_q   <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					dig_q[cnt_q] <= rem;
					cnt_q        <= cnt_q + 1'b1;
					mag_q        <= quo;
					if (quo == '0) begin
						pos_q   <= neg_q ? (cnt_q + 1'b1) : cnt_q;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						char_q      <= next_char;
						last_q      <= (pos_q == '0);
						if (pos_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							pos_q <= pos_q - 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign chr.valid     = out_valid_q;
	assign chr.char_code = char_q;
	assign chr.last      = last_q;

	// checks
	`ITOA_ASSERT_IMPL(a_minus_never_last, clk, arst_n, chr.valid && chr.char_code == CHAR_MINUS, !chr.last)
	`ITOA_ASSERT_NEXT(a_take_starts_work, clk, arst_n, cmd_valid && cmd_ready, state_q != ST_IDLE)
	`ITOA_ASSERT_IMPL(a_div_within_digits, clk, arst_n, state_q == ST_DIV, cnt_q < MAX_DEC_DIGITS)

endmodule

### bench/integer_to_ascii_converter_core_tb.sv
// testbench of integer_to_ascii_converter_core: numbers in, checked ascii characters out
// depends on itoa_pkg, itoa_if and the core; self-checking against its own formatter
module integer_to_ascii_converter_core_tb
	import itoa_pkg::*;
;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 10;
	localparam int RANDOM_ITEMS  = 220;
	localparam int DRAIN_CYCLES  = 40;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int MAX_CHARS     = 11;

	// format code with no defined meaning, handled as hex
	localparam logic [ACTION_W-1:0] FMT_UNUSED = 2'd3;

	// one expected character of a formatted number
	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last;
	} char_item_t;

	// formats each accepted number and checks the characters in order
	class char_scoreboard;
		char_item_t  expected_chars[$];
		int unsigned mismatches;
		int unsigned chars_checked;

		function new();
			mismatches    = 0;
			chars_checked = 0;
		endfunction

		function logic [CHAR_W-1:0] char_of_digit(input logic [3:0] digit);
			if (digit < 4'd10) begin
				return 8'h30 + CHAR_W'(digit);
			end
			return 8'h41 + CHAR_W'(digit - 4'd10);
		endfunction

		// text of one number, least significant character first, then queued reversed
		function void note_number(input logic [ACTION_W-1:0] fmt, input logic [VALUE_W-1:0] val);
			logic [CHAR_W-1:0] rev_chars [MAX_CHARS];
			logic [VALUE_W-1:0] mag;
			logic               neg;
			int unsigned        n;
			char_item_t         item;
			n   = 0;
			mag = val;
			neg = 1'b0;
			if (fmt[FMT_HEX_BIT]) begin
				do begin
					rev_chars[n] = char_of_digit(mag[3:0]);
					n++;
					mag = mag >> 4;
				end while (mag != '0 && n < HEX_DIGITS);
			end else begin
				// signed mode works on the magnitude, most negative value included
				if (fmt == FMT_SIGNED && val[VALUE_W-1]) begin
					neg = 1'b1;
					mag = VALUE_W'(0) - val;
				end
				do begin
					rev_chars[n] = char_of_digit(4'(mag % 10));
					n++;
					mag = mag / 10;
				end while (mag != '0 && n < 10);
				if (neg) begin
					rev_chars[n] = CHAR_MINUS;
					n++;
				end
			end
			for (int k = 0; k < n; k++) begin
				item.char_code = rev_chars[n - 1 - k];
				item.last      = (k + 1 == n);
				expected_chars.push_back(item);
			end
		endfunction

		// compare one accepted character with the oldest expectation
		function void check_char(input logic [CHAR_W-1:0] code, input logic last);
			char_item_t exp_item;
			chars_checked++;
			if (expected_chars.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected character, expected none, actual char_code %h last %b",
					$time, code, last);
				return;
			end
			exp_item = expected_chars.pop_front();
			if (code !== exp_item.char_code) begin
				mismatches++;
				$display("%0t: char_code mismatch, expected %h, actual %h",
					$time, exp_item.char_code, code);
			end
			if (last !== exp_item.last) begin
				mismatches++;
				$display("%0t: last mismatch, expected %b, actual %b", $time, exp_item.last, last);
			end
		endfunction

		function int unsigned pending();
			return expected_chars.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	itoa_num_if num_ch ();
	itoa_chr_if chr_ch ();

	integer_to_ascii_converter_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_ch.sink),
		.chr    (chr_ch.source)
	);

	char_scoreboard sb;
	int unsigned    src_idle_pct;
	int unsigned    snk_idle_pct;
	int unsigned    fmt_count [4];
	int unsigned    cycle_count;

	// all inputs known from time zero
	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		num_ch.valid  = 1'b0;
		num_ch.action = '0;
		num_ch.value  = '0;
		chr_ch.ready  = 1'b0;
		src_idle_pct  = 0;
		snk_idle_pct  = 0;
		sb            = new();
	end

	always #CLK_HALF clk = ~clk;

	// character sink: check accepted items, then pick the next ready
	always @(posedge clk) begin
		if (arst_n && chr_ch.valid && chr_ch.ready) begin
			sb.check_char(chr_ch.char_code, chr_ch.last);
		end
		chr_ch.ready <= arst_n && ($urandom_range(0, 99) >= snk_idle_pct);
	end

	// offer one number, holding it until the core takes it
	task automatic send_number(input logic [ACTION_W-1:0] fmt, input logic [VALUE_W-1:0] val);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			num_ch.valid <= 1'b0;
			@(posedge clk);
		end
		num_ch.valid  <= 1'b1;
		num_ch.action <= fmt;
		num_ch.value  <= val;
		do @(posedge clk); while (!num_ch.ready);
		sb.note_number(fmt, val);
		fmt_count[fmt]++;
	endtask

	// random numbers shaped toward short, full-width and boundary values
	task automatic send_random(input int count);
		logic [VALUE_W-1:0] val;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 3))
				0: val = $urandom;
				1: val = $urandom >> $urandom_range(0, 31);
				2: val = $urandom_range(0, 20);
				default: begin
					if ($urandom_range(0, 1) != 0) begin
						val = 32'h7FFF_FFFE + $urandom_range(0, 3);
					end else begin
						val = 32'hFFFF_FFFF - $urandom_range(0, 15);
					end
				end
			endcase
			send_number(ACTION_W'($urandom_range(0, 3)), val);
		end
	endtask

	// watchdog on total run length
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("simulation failed");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero, extremes, digit-count boundaries, every format
		send_number(FMT_UNSIGNED, 32'd0);
		send_number(FMT_UNSIGNED, 32'd9);
		send_number(FMT_UNSIGNED, 32'd10);
		send_number(FMT_UNSIGNED, 32'd1_000_000_000);
		send_number(FMT_UNSIGNED, 32'hFFFF_FFFF);
		send_number(FMT_SIGNED, 32'd0);
		send_number(FMT_SIGNED, 32'h7FFF_FFFF);
		// most negative value goes through its unsigned magnitude
		send_number(FMT_SIGNED, 32'h8000_0000);
		send_number(FMT_SIGNED, 32'hFFFF_FFFF);
		send_number(FMT_SIGNED, 32'hFFFF_FFF6);
		send_number(FMT_HEX, 32'd0);
		send_number(FMT_HEX, 32'h0000_0010);
		send_number(FMT_HEX, 32'hFFFF_FFFF);
		send_number(FMT_HEX, 32'h1234_ABCD);
		// unused format code falls back to hex
		send_number(FMT_UNUSED, 32'd0);
		send_number(FMT_UNUSED, 32'hA5C3_F00F);

		// random: receiver idles more, then sender, then neither
		src_idle_pct = 27;
		snk_idle_pct = 51;
		send_random(RANDOM_ITEMS / 3);
		src_idle_pct = 51;
		snk_idle_pct = 27;
		send_random(RANDOM_ITEMS / 3);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		send_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
		num_ch.valid <= 1'b0;

		// drain outstanding characters, then watch for strays
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("numbers sent: %0d unsigned, %0d signed, %0d hex, %0d unused-code",
			fmt_count[FMT_UNSIGNED], fmt_count[FMT_SIGNED], fmt_count[FMT_HEX],
			fmt_count[FMT_UNUSED]);
		$display("characters checked: %0d, mismatches: %0d", sb.chars_checked, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
